FILE: sv/gpio_prb_pkg.sv
// ----------------------------------------------------------------------------
// gpio_prb_pkg
// Types, register codes and field-spreading helpers for the gpio port block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpio_prb_pkg;

  // access kind codes
  localparam logic KindRead  = 1'b0;
  localparam logic KindWrite = 1'b1;

  // register index codes
  typedef enum logic [3:0] {
    RegMode     = 4'd0,
    RegOtype    = 4'd1,
    RegSpeed    = 4'd2,
    RegPull     = 4'd3,
    RegInput    = 4'd4,
    RegOutput   = 4'd5,
    RegSetReset = 4'd6,
    RegLock     = 4'd7,
    RegAfLow    = 4'd8,
    RegAfHigh   = 4'd9
  } reg_idx_e;

  // lock key sequencer, one-hot
  typedef enum logic [2:0] {
    KeyIdle   = 3'b001,
    KeyFirst  = 3'b010,
    KeySecond = 3'b100
  } key_phase_e;

  // position of the key bit in a lock register write
  localparam int unsigned LockKeyBit = 16;

  typedef struct packed {
    logic        kind;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [15:0] pin_levels;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] out_levels;
    logic        lock_active;
  } rsp_t;

  // one pin bit becomes a 2-bit field
  function automatic logic [31:0] spread2(input logic [15:0] pins);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i +: 2] = {2{pins[i]}};
    end
    return r;
  endfunction

  // one pin bit becomes a 4-bit field
  function automatic logic [31:0] spread4(input logic [7:0] pins);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = {4{pins[i]}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/gpio_port_register_block.sv
// ----------------------------------------------------------------------------
// gpio_port_register_block
// Register file of one general-purpose I/O port with a configuration lock key.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------
//  request | in        | req_valid_i/req_ready_o | req_i : req_t (one access)
//  response| out       | rsp_valid_o/rsp_ready_i | rsp_o : rsp_t (one result)
//
// the accepting edge loads the request register; once the response register
// is free, the port registers are updated and the response register is loaded,
// so each response passes through the request and response registers in turn.
// one transaction is accepted per cycle while the response side keeps up; a
// stalled response holds the pipeline, and the request register frees as soon
// as its transaction moves on. reset clears all port registers, the lock and
// the key sequencer; no clearing pass is needed.
`default_nettype none

module gpio_port_register_block
  import gpio_prb_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output      logic req_ready_o,
  input  wire req_t req_i,
  output      logic rsp_valid_o,
  input  wire logic rsp_ready_i,
  output      rsp_t rsp_o
);

  // bits of pins that exist; absent pins read zero and ignore writes
  localparam logic [15:0] PinMask = 16'((33'd1 << PIN_COUNT) - 33'd1);

  // request stage
  logic pipe_valid_q;
  req_t item_q;

  // response stage
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  // port registers
  logic [31:0] mode_q, mode_d;
  logic [15:0] otype_q, otype_d;
  logic [31:0] speed_q, speed_d;
  logic [31:0] pull_q, pull_d;
  logic [15:0] out_q, out_d;
  logic [31:0] af_low_q, af_low_d;
  logic [31:0] af_high_q, af_high_d;
  logic [15:0] lock_mask_q, lock_mask_d;
  logic        lock_key_q, lock_key_d;
  key_phase_e  key_phase_q, key_phase_d;
  logic [15:0] key_held_q, key_held_d;

  logic        advance;
  logic        is_write;
  logic [15:0] open_pins;
  logic [31:0] open2, open_al, open_ah;
  logic [31:0] wd;
  logic [15:0] wd_low;
  logic        wd_key;
  logic        key_match;
  logic [31:0] read_value;

  // the request register moves on when the response register is free
  assign advance     = pipe_valid_q && (!rsp_valid_q || rsp_ready_i);
  assign req_ready_o = !pipe_valid_q || advance;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign is_write  = (item_q.kind == KindWrite);
  assign wd        = item_q.write_data;
  assign wd_low    = wd[15:0];
  assign wd_key    = wd[LockKeyBit];
  assign key_match = (wd_low == key_held_q);

  // pins whose configuration may still change
  assign open_pins = PinMask & ~(lock_key_q ? lock_mask_q : 16'h0000);
  assign open2     = spread2(open_pins);
  assign open_al   = spread4(open_pins[7:0]);
  assign open_ah   = spread4(open_pins[15:8]);

  // register updates of the access in the request register
  always_comb begin
    mode_d      = mode_q;
    otype_d     = otype_q;
    speed_d     = speed_q;
    pull_d      = pull_q;
    out_d       = out_q;
    af_low_d    = af_low_q;
    af_high_d   = af_high_q;
    lock_mask_d = lock_mask_q;
    lock_key_d  = lock_key_q;
    key_phase_d = key_phase_q;
    key_held_d  = key_held_q;
    if (advance && is_write) begin
      case (item_q.reg_index)
        RegMode:   mode_d    = (mode_q & ~open2) | (wd & open2);
        RegOtype:  otype_d   = (otype_q & ~open_pins) | (wd_low & open_pins);
        RegSpeed:  speed_d   = (speed_q & ~open2) | (wd & open2);
        RegPull:   pull_d    = (pull_q & ~open2) | (wd & open2);
        RegOutput: out_d     = wd_low & PinMask;
        // set wins over reset for a pin named in both halves
        RegSetReset: out_d   = ((out_q & ~wd[31:16]) | wd_low) & PinMask;
        RegAfLow:  af_low_d  = (af_low_q & ~open_al) | (wd & open_al);
        RegAfHigh: af_high_d = (af_high_q & ~open_ah) | (wd & open_ah);
        RegLock: begin
          if (!lock_key_q) begin
            lock_mask_d = wd_low & PinMask;
            // key: 1, 0, 1 on the key bit with the same low half
            case (key_phase_q)
              KeyFirst: begin
                if (!wd_key && key_match) begin
                  key_phase_d = KeySecond;
                end else if (wd_key) begin
                  key_held_d  = wd_low;
                  key_phase_d = KeyFirst;
                end else begin
                  key_phase_d = KeyIdle;
                end
              end
              KeySecond: begin
                if (wd_key && key_match) begin
                  lock_key_d  = 1'b1;
                  key_phase_d = KeyIdle;
                end else if (wd_key) begin
                  key_held_d  = wd_low;
                  key_phase_d = KeyFirst;
                end else begin
                  key_phase_d = KeyIdle;
                end
              end
              default: begin
                if (wd_key) begin
                  key_held_d  = wd_low;
                  key_phase_d = KeyFirst;
                end else begin
                  key_phase_d = KeyIdle;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // read mux; writes and the set/reset word return zero
  always_comb begin
    read_value = '0;
    if (!is_write) begin
      case (item_q.reg_index)
        RegMode:   read_value = mode_q;
        RegOtype:  read_value = {16'h0000, otype_q};
        RegSpeed:  read_value = speed_q;
        RegPull:   read_value = pull_q;
        RegInput:  read_value = {16'h0000, item_q.pin_levels & PinMask};
        RegOutput: read_value = {16'h0000, out_q};
        RegLock:   read_value = {15'h0000, lock_key_q, lock_mask_q};
        RegAfLow:  read_value = af_low_q;
        RegAfHigh: read_value = af_high_q;
        default:   read_value = '0;
      endcase
    end
  end

  // response carries the port state after the access
  always_comb begin
    rsp_d.read_data   = read_value;
    rsp_d.out_levels  = out_d;
    rsp_d.lock_active = lock_key_d;
    if (advance) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
    end else if (req_ready_o) begin
      pipe_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      item_q <= req_i;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  // port registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      otype_q     <= '0;
      speed_q     <= '0;
      pull_q      <= '0;
      out_q       <= '0;
      af_low_q    <= '0;
      af_high_q   <= '0;
      lock_mask_q <= '0;
      lock_key_q  <= 1'b0;
      key_phase_q <= KeyIdle;
      key_held_q  <= '0;
    end else begin
      mode_q      <= mode_d;
      otype_q     <= otype_d;
      speed_q     <= speed_d;
      pull_q      <= pull_d;
      out_q       <= out_d;
      af_low_q    <= af_low_d;
      af_high_q   <= af_high_d;
      lock_mask_q <= lock_mask_d;
      lock_key_q  <= lock_key_d;
      key_phase_q <= key_phase_d;
      key_held_q  <= key_held_d;
    end
  end

  // once locked, stays locked until reset
  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_key_q |=> lock_key_q)
    else $error("lock released without reset");

  // the lock mask is frozen while locked
  a_mask_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_key_q |=> $stable(lock_mask_q))
    else $error("lock mask changed while locked");

  // the lock only engages on a lock register write leaving the request stage
  a_lock_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(lock_key_q) |-> $past(advance && is_write && (item_q.reg_index == RegLock)))
    else $error("lock set without a lock write");

  // output data never drives absent pins
  a_out_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_q & ~PinMask) == 16'h0000)
    else $error("output data on an absent pin");

endmodule

`default_nettype wire
